@@ src/multichannel_integrating_debouncer_defines.svh @@
// Assertion macros shared by the debouncer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MULTICHANNEL_INTEGRATING_DEBOUNCER_DEFINES_SVH
`define MULTICHANNEL_INTEGRATING_DEBOUNCER_DEFINES_SVH

`ifndef SYNTHESIS
`define MCID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCID_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MCID_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCID_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ src/mcid_pkg.sv @@
// Types, codes and constants of the multichannel integrating debouncer.
// No dependencies; imported by the register block and the top level.
`default_nettype none

package mcid_pkg;

  localparam int NumChannelsDef = 14;
  localparam int ChW            = 4;
  localparam int IntW           = 8;
  localparam int CntW           = 32;
  localparam int CfgAddrW       = 4;
  localparam int CfgDataW       = 32;

  localparam logic [IntW-1:0] StartCountRst   = 8'd10;
  localparam logic [IntW-1:0] ThresholdRst    = 8'd255;
  localparam logic [IntW-1:0] HoldoffTicksRst = 8'd4;

  typedef enum logic [1:0] {
    REG_START_COUNT   = 2'd0,
    REG_THRESHOLD     = 2'd1,
    REG_HOLDOFF_TICKS = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_LOAD   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_STARTED   = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_COUNTING  = 3'd3,
    ST_QUALIFIED = 3'd4,
    ST_ABORTED   = 3'd5,
    ST_HOLDOFF   = 3'd6,
    ST_LOADED    = 3'd7
  } status_e;

  typedef struct packed {
    logic [IntW-1:0] start_count;
    logic [IntW-1:0] threshold;
    logic [IntW-1:0] holdoff_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [ChW-1:0]  channel;
    logic            level;
    logic [CntW-1:0] load_value;
  } in_t;

  typedef struct packed {
    logic [ChW-1:0]  out_channel;
    logic [2:0]      status;
    logic [CntW-1:0] event_count;
    logic            busy_res;
  } out_t;

  // One memory word per channel
  typedef struct packed {
    logic            run;
    logic            hold;
    logic [IntW-1:0] integ;
    logic [IntW-1:0] hold_left;
    logic [CntW-1:0] count;
  } ch_state_t;

endpackage

`default_nettype wire

@@ src/mcid_regs.sv @@
// APB-style configuration registers of the debouncer.
// Depends on mcid_pkg for the register map and the cfg_t bundle.
`default_nettype none

module mcid_regs
  import mcid_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = reg_e'(paddr[CfgAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_START_COUNT:   cfg_d.start_count   = pwdata[IntW-1:0];
        REG_THRESHOLD:     cfg_d.threshold     = pwdata[IntW-1:0];
        REG_HOLDOFF_TICKS: cfg_d.holdoff_ticks = pwdata[IntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_START_COUNT:   prdata = CfgDataW'(cfg_q.start_count);
      REG_THRESHOLD:     prdata = CfgDataW'(cfg_q.threshold);
      REG_HOLDOFF_TICKS: prdata = CfgDataW'(cfg_q.holdoff_ticks);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_count   <= StartCountRst;
      cfg_q.threshold     <= ThresholdRst;
      cfg_q.holdoff_ticks <= HoldoffTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ src/multichannel_integrating_debouncer.sv @@
// Multichannel integrating debouncer: item channel in, one result item out per input item.
// Input items (in_data_i) carry an op: rising edge, level sample tick or event counter load,
// addressed to one channel. Each produces exactly one result item (out_data_o) giving the
// status, the channel's event counter and whether the channel is still busy.
// Both channels use valid/stall; an item moves when valid is high and stall is low.
// A result is registered: the memory is read at the edge that accepts its item, and the
// update lands in the output register once the update stage can advance.
// Throughput: one item per cycle unless stalled. Per-channel state sits in a single memory
// with one read and one write per cycle; written-back words are forwarded to the next item.
// When out_stall_i holds a result, the update stage holds too and in_stall_o rises only
// once that stage is occupied, so one further item is still taken.
// Reset clears all channel state (per-entry valid bits, no clearing pass) and loads
// start_count 10, threshold 255, holdoff_ticks 4. Registers sit on the APB-style port at
// byte addresses 0, 4 and 8. User rule, not enforced: write only while no item is in flight.
// Depends on mcid_pkg, mcid_regs and the assertion macro header.
`default_nettype none
`include "multichannel_integrating_debouncer_defines.svh"

module multichannel_integrating_debouncer
  import mcid_pkg::*;
#(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_t                 in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_t                     out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cfg_t cfg;

  mcid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // channel state memory
  ch_state_t mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid_q;

  logic            acc_in;
  logic [IdxW-1:0] in_idx;
  logic            in_inr;

  logic            s1_vld_q;
  in_t             s1_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_inr_q;
  ch_state_t       rd_q;
  logic            rd_vld_q;
  logic            s1_adv;
  logic            mem_we;

  logic            fwd_vld_q;
  logic [IdxW-1:0] fwd_idx_q;
  ch_state_t       fwd_q;

  ch_state_t       cur;
  ch_state_t       nxt;
  status_e         status;
  out_t            res;

  logic            out_vld_q;
  out_t            out_q;

  assign acc_in = in_valid_i & ~in_stall_o;
  assign in_idx = IdxW'(in_data_i.channel);
  assign in_inr = 32'(in_data_i.channel) < NUM_CHANNELS;

  assign s1_adv     = ~out_vld_q | ~out_stall_i;
  assign in_stall_o = s1_vld_q & ~s1_adv;
  assign mem_we     = s1_vld_q & s1_adv & s1_inr_q;

  always_ff @(posedge clk_i) begin
    if (acc_in && in_inr) begin
      rd_q <= mem_q[in_idx];
    end
    if (mem_we) begin
      mem_q[s1_idx_q] <= nxt;
    end
  end

  // the word written at the same edge as the read is not yet seen by it
  assign cur = (fwd_vld_q && fwd_idx_q == s1_idx_q) ? fwd_q :
               (rd_vld_q ? rd_q : '0);

  always_comb begin
    logic            do_settle;
    logic [IntW-1:0] integ;
    status_e         ok_status;
    nxt       = cur;
    status    = ST_IDLE;
    do_settle = 1'b0;
    integ     = cur.integ;
    ok_status = ST_COUNTING;
    case (op_e'(s1_q.op))
      OP_EDGE: begin
        if (cur.run || cur.hold) begin
          status = ST_IGNORED;
        end else begin
          integ     = cfg.start_count;
          do_settle = 1'b1;
          ok_status = ST_STARTED;
        end
      end
      OP_SAMPLE: begin
        if (cur.run) begin
          integ     = s1_q.level ? cur.integ + 1'b1 : cur.integ - 1'b1;
          do_settle = 1'b1;
        end else if (cur.hold) begin
          nxt.hold_left = cur.hold_left - 1'b1;
          nxt.hold      = (nxt.hold_left != '0);
          status        = ST_HOLDOFF;
        end
      end
      OP_LOAD: begin
        nxt.count = s1_q.load_value;
        status    = ST_LOADED;
      end
      default: ;
    endcase
    if (do_settle) begin
      nxt.integ = integ;
      if (integ >= cfg.threshold) begin
        nxt.count = cur.count + 1'b1;
        nxt.run   = 1'b0;
        status    = ST_QUALIFIED;
      end else if (integ == '0) begin
        nxt.run       = 1'b0;
        nxt.hold_left = cfg.holdoff_ticks;
        nxt.hold      = (cfg.holdoff_ticks != '0);
        status        = ST_ABORTED;
      end else begin
        nxt.run = 1'b1;
        status  = ok_status;
      end
    end
  end

  always_comb begin
    res.out_channel = s1_q.channel;
    if (s1_inr_q) begin
      res.status      = 3'(status);
      res.event_count = nxt.count;
      res.busy_res    = nxt.run | nxt.hold;
    end else begin
      res.status      = 3'(ST_IDLE);
      res.event_count = '0;
      res.busy_res    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      valid_q   <= '0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc_in) begin
        s1_vld_q <= 1'b1;
        rd_vld_q <= in_inr & valid_q[in_idx];
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (mem_we) begin
        valid_q[s1_idx_q] <= 1'b1;
        fwd_vld_q         <= 1'b1;
      end
      if (s1_adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      s1_q     <= in_data_i;
      s1_idx_q <= in_idx;
      s1_inr_q <= in_inr;
    end
    if (mem_we) begin
      fwd_q     <= nxt;
      fwd_idx_q <= s1_idx_q;
    end
    if (s1_adv && s1_vld_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `MCID_ASSERT(a_stall_needs_item, clk_i, rst_ni, !s1_vld_q |-> !in_stall_o, "stall with empty update stage")
  `MCID_ASSERT(a_accept_fills_s1, clk_i, rst_ni, acc_in |=> s1_vld_q, "accepted item lost before update stage")
  `MCID_ASSERT(a_write_forwarded, clk_i, rst_ni, mem_we |=> (fwd_vld_q && fwd_idx_q == $past(s1_idx_q)), "write-back not captured for forwarding")
  `MCID_ASSERT_NEVER(a_qual_idle, clk_i, rst_ni, out_vld_q && out_q.status == 3'(ST_QUALIFIED) && out_q.busy_res, "qualified channel reported busy")
  `MCID_ASSERT_NEVER(a_start_busy, clk_i, rst_ni, out_vld_q && out_q.status == 3'(ST_STARTED) && !out_q.busy_res, "started run reported idle")

endmodule

`default_nettype wire
